>>> rtl/integer_set_table_unit_assert.svh
// Assertion macros used by the datapath of the integer set table.
`ifndef INTEGER_SET_TABLE_UNIT_ASSERT_SVH
`define INTEGER_SET_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISTU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/istu_pkg.sv
`timescale 1ns / 1ps

package istu_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 7;
   localparam int COUNT_W    = 8;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       shift_start;
      logic       shift;
      logic       append;
      logic       clear;
      logic       dec;
      logic       publish;
      logic [1:0] status;
   } istu_cmd_type;

   typedef struct packed {
      logic       match;
      logic       exhausted;
      logic       full;
      logic       rsp_free;
      logic [1:0] op;
   } istu_stat_type;

endpackage

>>> rtl/istu_ctrl.sv
`timescale 1ns / 1ps

module istu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  istu_pkg::istu_stat_type stat,
   output istu_pkg::istu_cmd_type  cmd
);
   import istu_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [1:0] code_ff;
   logic [1:0] code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.status = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.op == OP_CLEAR) begin
               cmd.clear = 1'b1;
               code_in   = ST_DONE;
               state_in  = S_DONE;
            end else begin
               cmd.scan = 1'b1;
               if (stat.match) begin
                  if (stat.op == OP_INSERT) begin
                     code_in  = ST_PRESENT;
                     state_in = S_DONE;
                  end else if (stat.op == OP_REMOVE) begin
                     cmd.shift_start = 1'b1;
                     code_in         = ST_DONE;
                     state_in        = S_SHIFT;
                  end else begin
                     code_in  = ST_DONE;
                     state_in = S_DONE;
                  end
               end else if (stat.exhausted) begin
                  if (stat.op == OP_INSERT) begin
                     if (stat.full) begin
                        code_in = ST_FULL;
                     end else begin
                        cmd.append = 1'b1;
                        code_in    = ST_DONE;
                     end
                  end else begin
                     code_in = ST_MISSING;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.exhausted) begin
               cmd.dec  = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

>>> rtl/istu_dp.sv
`timescale 1ns / 1ps

module istu_dp #(
   parameter int CAPACITY = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_op,
   input  logic signed [istu_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [istu_pkg::POSITION_W-1:0]     rsp_position,
   output logic [istu_pkg::COUNT_W-1:0]        rsp_count,
   input  istu_pkg::istu_cmd_type              cmd,
   output istu_pkg::istu_stat_type             stat
);
   import istu_pkg::*;
   `include "integer_set_table_unit_assert.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0] entries_mem [CAPACITY];

   logic [1:0]                op_ff;
   logic [1:0]                op_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          ptr_ff;
   logic [CNT_W-1:0]          ptr_in;
   logic                      pend_ff;
   logic                      pend_in;
   logic [IDX_W-1:0]          pidx_ff;
   logic [IDX_W-1:0]          pidx_in;
   logic [VALUE_W-1:0]        rdata_ff;
   logic                      hit_ff;
   logic                      hit_in;
   logic [IDX_W-1:0]          slot_ff;
   logic [IDX_W-1:0]          slot_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [1:0]                rsp_status_ff;
   logic                      rsp_found_ff;
   logic [POSITION_W-1:0]     rsp_position_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic                      rd_en;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic                      match;
   logic [IDX_W+POSITION_W-1:0] slot_wide;
   logic [CNT_W+COUNT_W-1:0]    count_wide;

   assign match   = pend_ff && (rdata_ff == value_ff);
   assign rd_en   = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);
   assign wr_en   = cmd.append || (cmd.shift && pend_ff);
   assign wr_addr = cmd.append ? count_ff[IDX_W-1:0] : (pidx_ff - IDX_W'(1));
   assign wr_data = cmd.append ? value_ff : rdata_ff;

   assign slot_wide  = {{POSITION_W{1'b0}}, slot_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_comb begin
      op_in    = op_ff;
      value_in = value_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pend_in  = rd_en;
      pidx_in  = rd_en ? ptr_ff[IDX_W-1:0] : pidx_ff;
      hit_in   = hit_ff;
      slot_in  = slot_ff;
      if (rd_en) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.load) begin
         op_in    = req_op;
         value_in = req_value;
         ptr_in   = '0;
         pend_in  = 1'b0;
         hit_in   = 1'b0;
         slot_in  = '0;
      end
      if (cmd.scan && match) begin
         hit_in  = 1'b1;
         slot_in = pidx_ff;
      end
      if (cmd.shift_start) begin
         ptr_in  = CNT_W'(pidx_ff) + CNT_W'(1);
         pend_in = 1'b0;
      end
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entries_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      ptr_ff   <= ptr_in;
      pidx_ff  <= pidx_in;
      hit_ff   <= hit_in;
      slot_ff  <= slot_in;
      if (cmd.publish) begin
         rsp_status_ff   <= cmd.status;
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= slot_wide[POSITION_W-1:0];
         rsp_count_ff    <= count_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.match     = match;
   assign stat.exhausted = !pend_ff && (ptr_ff >= count_ff);
   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign stat.op        = op_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   `ISTU_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "Element count exceeds capacity.")
   `ISTU_ASSERT_SAME(a_append_room, clock, reset, cmd.append, !stat.full,
      "Append issued into a full table.")
   `ISTU_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, count_ff == '0,
      "Clear did not empty the table.")
   `ISTU_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff,
      "Published response is not marked valid.")

endmodule

>>> rtl/integer_set_table_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_op, req_value
// rsp       out        rsp_valid / rsp_ready   rsp_status, rsp_found, rsp_position, rsp_count
//
// One request is handled at a time; the next is taken in the cycle after its result is stored.
// Insert, search and remove walk the entry memory one read per cycle; a remove then shifts
// the later entries down one slot, reading and writing the memory in the same cycle.
// Clear only zeroes the element count. Reset empties the set at once; no clearing pass is needed.
// A stalled response waits in the output register while the next request is taken in.

module integer_set_table_unit #(
   parameter int CAPACITY = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic signed [istu_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [istu_pkg::POSITION_W-1:0]     rsp_position,
   output logic [istu_pkg::COUNT_W-1:0]        rsp_count
);
   import istu_pkg::*;

   istu_cmd_type  cmd;
   istu_stat_type stat;

   istu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   istu_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule

>>> tb/sv/integer_set_table_unit_tb.sv
`timescale 1ns / 1ps

module integer_set_table_unit_tb;

   import istu_pkg::*;

   localparam int SET_CAPACITY = 128;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 2 * SET_CAPACITY + 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int POOL_SIZE    = 48;
   localparam int IDLE_PERCENT = 36;

   typedef struct packed {
      logic [1:0]            status;
      logic                  found;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    count;
   } set_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_op = OP_INSERT;
   logic signed [VALUE_W-1:0]     req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic                          rsp_found;
   logic [POSITION_W-1:0]         rsp_position;
   logic [COUNT_W-1:0]            rsp_count;

   logic [VALUE_W-1:0] set_members[$];
   set_result_type     pending_results[$];
   logic [VALUE_W-1:0] value_pool[POOL_SIZE];
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   bit                 req_gap_on = 1'b1;
   bit                 rsp_gap_on = 1'b1;
   bit                 hold_pending = 1'b0;
   int                 hold_left = 0;

   integer_set_table_unit #(
      .CAPACITY(SET_CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .rsp_count(rsp_count)
   );

   always #5 clock = ~clock;

   function automatic int find_member(logic [VALUE_W-1:0] v);
      foreach (set_members[i]) begin
         if (set_members[i] == v) return i;
      end
      return -1;
   endfunction

   function automatic set_result_type apply_set_op(logic [1:0] op, logic [VALUE_W-1:0] v);
      set_result_type r;
      int             slot;
      r = '0;
      r.status = ST_DONE;
      slot = find_member(v);
      if (op == OP_CLEAR) begin
         set_members.delete();
      end else begin
         if (slot >= 0) begin
            r.found = 1'b1;
            r.position = POSITION_W'(slot);
         end
         case (op)
            OP_INSERT: begin
               if (slot >= 0) r.status = ST_PRESENT;
               else if (set_members.size() >= SET_CAPACITY) r.status = ST_FULL;
               else set_members.push_back(v);
            end
            OP_REMOVE: begin
               if (slot >= 0) set_members.delete(slot);
               else r.status = ST_MISSING;
            end
            default: begin
               if (slot < 0) r.status = ST_MISSING;
            end
         endcase
      end
      r.count = COUNT_W'(set_members.size());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_request(input logic [1:0] op, input logic [VALUE_W-1:0] v);
      if (req_gap_on) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_set_op(op, v));
   endtask

   always @(posedge clock) begin : response_check
      set_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unrequested response status", rsp_status, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_found !== want.found) report_mismatch("found", rsp_found, want.found);
            if (rsp_position !== want.position) begin
               report_mismatch("position", rsp_position, want.position);
            end
            if (rsp_count !== want.count) report_mismatch("count", rsp_count, want.count);
         end
      end
      if (hold_pending) begin
         hold_left = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap_on) begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic test_basic_ops();
      send_request(OP_SEARCH, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0001);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 32'h0000_0001);
      send_request(OP_REMOVE, 32'h0000_0001);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h1234_5678);
      send_request(OP_CLEAR, 32'hA5A5_A5A5);
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h5A5A_5A5A);
      send_request(OP_SEARCH, 32'h5A5A_5A5A);
      send_request(OP_CLEAR, 32'h0000_0000);
   endtask

   task automatic test_fill_to_capacity();
      logic [VALUE_W-1:0] v;
      while (set_members.size() < SET_CAPACITY) begin
         v = $urandom();
         if (find_member(v) < 0) send_request(OP_INSERT, v);
      end
      do v = $urandom(); while (find_member(v) >= 0);
      send_request(OP_INSERT, v);
      send_request(OP_INSERT, set_members[0]);
      send_request(OP_SEARCH, set_members[SET_CAPACITY-1]);
      send_request(OP_REMOVE, set_members[0]);
      send_request(OP_INSERT, v);
      send_request(OP_SEARCH, v);
      send_request(OP_REMOVE, v);
      send_request(OP_CLEAR, v);
   endtask

   task automatic test_backpressure();
      hold_pending = 1'b1;
      req_gap_on = 1'b0;
      for (int k = 0; k < 10; k++) begin
         send_request((k % 3 == 2) ? OP_SEARCH : OP_INSERT, $urandom());
      end
      req_gap_on = 1'b1;
   endtask

   task automatic test_random_mix(input int n_items);
      logic [1:0]         op;
      logic [VALUE_W-1:0] v;
      int                 pick;
      foreach (value_pool[i]) value_pool[i] = $urandom();
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int k = 0; k < n_items; k++) begin
         req_gap_on = !(k >= n_items / 3 && k < n_items / 2);
         rsp_gap_on = req_gap_on;
         pick = $urandom_range(99);
         if (pick < 42) op = OP_INSERT;
         else if (pick < 62) op = OP_REMOVE;
         else if (pick < 97) op = OP_SEARCH;
         else op = OP_CLEAR;
         pick = $urandom_range(99);
         if (pick < 15) v = $urandom();
         else if (pick < 55 && set_members.size() > 0)
            v = set_members[$urandom_range(set_members.size() - 1)];
         else v = value_pool[$urandom_range(POOL_SIZE - 1)];
         send_request(op, v);
      end
      req_gap_on = 1'b1;
      rsp_gap_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_fill_to_capacity();
      test_backpressure();
      test_random_mix(230);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/istu_pkg.sv
rtl/istu_ctrl.sv
rtl/istu_dp.sv
rtl/integer_set_table_unit.sv
tb/sv/integer_set_table_unit_tb.sv
